@@ hw/rtl/jhpv_pkg.sv @@
// Shared types, sizes and codes of the joint histogram block.
package jhpv_pkg;

  localparam int VOLUME_SIDE = 64;
  localparam int MAX_BINS    = 256;
  localparam int POS_W       = $clog2(VOLUME_SIDE);
  localparam int VOL_AW      = 3 * POS_W;
  localparam int VOL_DEPTH   = VOLUME_SIDE * VOLUME_SIDE * VOLUME_SIDE;
  localparam int BIN_IW      = $clog2(MAX_BINS);
  localparam int BIN_AW      = 2 * BIN_IW;
  localparam int BIN_DEPTH   = MAX_BINS * MAX_BINS;
  localparam int COEFF_COUNT = 12;
  localparam int LABEL_W     = BIN_IW + 1;

  // Shared multiplier operand and product widths.
  localparam int MUL_AW = 35;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Command codes.
  localparam logic [2:0] MODE_WRITE_TARGET = 3'd0;
  localparam logic [2:0] MODE_WRITE_COEFF  = 3'd1;
  localparam logic [2:0] MODE_CLEAR        = 3'd2;
  localparam logic [2:0] MODE_ACCUMULATE   = 3'd3;
  localparam logic [2:0] MODE_READ_BIN     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INTERP_MODE = 3'd0;
  localparam logic [2:0] CFG_SOURCE_BINS = 3'd1;
  localparam logic [2:0] CFG_TARGET_BINS = 3'd2;
  localparam logic [2:0] CFG_EXTENT_X    = 3'd3;
  localparam logic [2:0] CFG_EXTENT_Y    = 3'd4;
  localparam logic [2:0] CFG_EXTENT_Z    = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [5:0]         pos_z;
    logic signed [15:0] level;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic [7:0]         read_row;
    logic [7:0]         read_col;
  } request_t;

  typedef struct packed {
    logic [39:0] bin_value;
    logic        voxel_used;
    logic [3:0]  neighbour_count;
  } result_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_AFF_MUL,
    ST_AFF_ADD,
    ST_AFF_CHECK,
    ST_NB_ADDR,
    ST_NB_LABEL,
    ST_NB_W1,
    ST_NB_W2,
    ST_BIN_WR,
    ST_TRI_MUL,
    ST_TRI_ADD,
    ST_NB_NEXT,
    ST_DIV,
    ST_TRI_RD,
    ST_TRI_WR,
    ST_READ_OUT
  } state_t;

endpackage

@@ hw/rtl/jhpv_mul.sv @@
// Shared signed multiplier with a registered product.
module jhpv_mul
  import jhpv_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [MUL_PW-1:0] p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

@@ hw/rtl/joint_histogram_pv_trilinear.sv @@
// Top level of the joint histogram builder: sequencer, memories and registers.
//
// Requests enter on request when start is high and busy is low. Every request
// gives exactly one result on result, shown for one cycle while done is high;
// the receiver cannot stall, so it must take the result in that cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data at any edge.
// Steps per request, from the accepting edge to the edge that takes the result:
//   target write, coefficient write, unknown mode: decode, then the result
//   bin read: decode, memory read, then the result
//   histogram clear: a sweep over all 65536 bins, one bin written per cycle
//   accumulate: decode, ending there if the intensity is rejected; then for each
//     mapped axis three products on the shared multiplier and a range check, ending
//     early at the first axis that falls outside; then per neighbour an address
//     check, a label read and check, a weight product and either a partial-volume
//     bin update or a trilinear product; for trilinear with a nonzero weight sum,
//     a division and a bin update; then the result.
// The multiplier and the single-port label and bin memories set these steps.
// After reset the block sweeps all 65536 bins to zero, one per cycle, and holds
// busy high for that time; configuration writes are taken meanwhile.
module joint_histogram_pv_trilinear
  import jhpv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  request_t   request,
  output logic       busy,
  output logic       done,
  output result_t    result,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int ACC_W = 42;
  localparam logic signed [ACC_W-1:0] ONE_Q16 = ACC_W'(65536);

  state_t state, state_next;
  request_t req;

  // Configuration registers.
  logic       interp_mode;
  logic [8:0] source_bins, target_bins;
  logic [6:0] extent_x, extent_y, extent_z;

  logic signed [31:0] coeff [COEFF_COUNT];

  // Sequencer registers.
  logic [1:0]              axis, term;
  logic signed [ACC_W-1:0] acc;
  logic signed [6:0]       flx, fly, flz;
  logic [15:0]             frx, fry, frz;
  logic [2:0]              k;
  logic [LABEL_W-1:0]      lab;
  logic [16:0]             wt;
  logic [19:0]             sum_w;
  logic [27:0]             sum_n;
  logic [28:0]             rem, dsh;
  logic [7:0]              quo;
  logic [2:0]              step;
  logic [3:0]              nn;
  logic [BIN_AW-1:0]       clr;
  logic                    clr_report;

  // Memories.
  logic [LABEL_W-1:0] tv_mem [VOL_DEPTH];
  logic [39:0]        bin_mem [BIN_DEPTH];
  logic               tv_we, bin_we;
  logic [VOL_AW-1:0]  tv_addr;
  logic [LABEL_W-1:0] tv_wdata, tv_q;
  logic [BIN_AW-1:0]  bin_addr;
  logic [39:0]        bin_wdata, bin_q;

  // Multiplier.
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;

  // Derived values.
  logic [8:0]  sb, tb;
  logic [6:0]  ex, ey, ez, ext_sel;
  logic [5:0]  pos_sel;
  logic signed [7:0] nx, ny, nz;
  logic        nb_inside, lab_ok, aff_inside, level_ok;
  logic signed [ACC_W-1:0] t1, lim;
  logic [16:0] wx, wy, wz, wt_calc;
  logic [49:0] wt_round;
  logic        fin, fin_used;
  logic [39:0] fin_bin;
  logic [3:0]  fin_count;

  function automatic logic [39:0] sat_add(input logic [39:0] v, input logic [16:0] amt);
    logic [40:0] s;
    s = {1'b0, v} + 41'(amt);
    return s[40] ? {40{1'b1}} : s[39:0];
  endfunction

  jhpv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign busy = (state != ST_IDLE);

  // Effective sizes.
  assign sb = (source_bins > 9'(MAX_BINS)) ? 9'(MAX_BINS) : source_bins;
  assign tb = (target_bins > 9'(MAX_BINS)) ? 9'(MAX_BINS) : target_bins;
  assign ex = (extent_x > 7'(VOLUME_SIDE)) ? 7'(VOLUME_SIDE) : extent_x;
  assign ey = (extent_y > 7'(VOLUME_SIDE)) ? 7'(VOLUME_SIDE) : extent_y;
  assign ez = (extent_z > 7'(VOLUME_SIDE)) ? 7'(VOLUME_SIDE) : extent_z;

  // Axis selection for the affine map.
  always_comb begin
    unique case (axis)
      2'd0:    ext_sel = ex;
      2'd1:    ext_sel = ey;
      default: ext_sel = ez;
    endcase
    unique case (term)
      2'd0:    pos_sel = req.pos_x;
      2'd1:    pos_sel = req.pos_y;
      default: pos_sel = req.pos_z;
    endcase
  end

  assign level_ok   = !req.level[15] && ($unsigned(req.level) < 16'(sb));
  assign lim        = ACC_W'(ext_sel) <<< 16;
  assign aff_inside = (acc > -ONE_Q16) && (acc < lim);
  assign t1         = acc + ONE_Q16;

  // Neighbour coordinates and weights.
  assign nx = 8'(flx) + 8'(k[2]);
  assign ny = 8'(fly) + 8'(k[1]);
  assign nz = 8'(flz) + 8'(k[0]);
  assign nb_inside = !nx[7] && !ny[7] && !nz[7] &&
                     (nx[6:0] < ex) && (ny[6:0] < ey) && (nz[6:0] < ez);
  assign lab_ok = !tv_q[LABEL_W-1] && (9'(tv_q[BIN_IW-1:0]) < tb);
  assign wx = k[2] ? {1'b0, frx} : 17'h10000 - 17'(frx);
  assign wy = k[1] ? {1'b0, fry} : 17'h10000 - 17'(fry);
  assign wz = k[0] ? {1'b0, frz} : 17'h10000 - 17'(frz);
  assign wt_round = 50'(mul_p[48:0]) + 50'h0_8000_0000;
  assign wt_calc  = wt_round[48:32];

  // Next state, memory controls and multiplier operands.
  always_comb begin
    state_next = state;
    tv_we      = 1'b0;
    tv_addr    = {nx[5:0], ny[5:0], nz[5:0]};
    tv_wdata   = '0;
    bin_we     = 1'b0;
    bin_addr   = {req.level[BIN_IW-1:0], lab[BIN_IW-1:0]};
    bin_wdata  = '0;
    mul_a      = '0;
    mul_b      = '0;
    fin        = 1'b0;
    fin_used   = 1'b0;
    fin_bin    = '0;
    fin_count  = '0;
    unique case (state)
      ST_CLEAR: begin
        bin_we   = 1'b1;
        bin_addr = clr;
        if (clr == {BIN_AW{1'b1}}) begin
          state_next = ST_IDLE;
          fin        = clr_report;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        unique case (req.mode)
          MODE_WRITE_TARGET: begin
            tv_we    = 1'b1;
            tv_addr  = {req.pos_x, req.pos_y, req.pos_z};
            tv_wdata = (req.level[15] || (req.level >= 16'sd256)) ?
                       {1'b1, {BIN_IW{1'b0}}} : {1'b0, req.level[BIN_IW-1:0]};
            fin      = 1'b1;
          end
          MODE_CLEAR: begin
            state_next = ST_CLEAR;
          end
          MODE_ACCUMULATE: begin
            if (level_ok) begin
              state_next = ST_AFF_MUL;
            end else begin
              fin = 1'b1;
            end
          end
          MODE_READ_BIN: begin
            bin_addr   = {req.read_row, req.read_col};
            state_next = ST_READ_OUT;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_AFF_MUL: begin
        mul_a      = MUL_AW'(coeff[{axis, term}]);
        mul_b      = MUL_BW'({1'b0, pos_sel});
        state_next = ST_AFF_ADD;
      end
      ST_AFF_ADD: begin
        state_next = (term == 2'd2) ? ST_AFF_CHECK : ST_AFF_MUL;
      end
      ST_AFF_CHECK: begin
        if (!aff_inside) begin
          state_next = ST_IDLE;
          fin        = 1'b1;
        end else if (axis == 2'd2) begin
          state_next = ST_NB_ADDR;
        end else begin
          state_next = ST_AFF_MUL;
        end
      end
      ST_NB_ADDR: begin
        state_next = nb_inside ? ST_NB_LABEL : ST_NB_NEXT;
      end
      ST_NB_LABEL: begin
        mul_a      = MUL_AW'(wx);
        mul_b      = MUL_BW'(wy);
        state_next = lab_ok ? ST_NB_W1 : ST_NB_NEXT;
      end
      ST_NB_W1: begin
        mul_a      = MUL_AW'(mul_p[33:0]);
        mul_b      = MUL_BW'(wz);
        state_next = ST_NB_W2;
      end
      ST_NB_W2: begin
        state_next = interp_mode ? ST_TRI_MUL : ST_BIN_WR;
      end
      ST_BIN_WR: begin
        bin_we     = 1'b1;
        bin_wdata  = sat_add(bin_q, wt);
        state_next = ST_NB_NEXT;
      end
      ST_TRI_MUL: begin
        mul_a      = MUL_AW'(wt);
        mul_b      = MUL_BW'(lab);
        state_next = ST_TRI_ADD;
      end
      ST_TRI_ADD: begin
        state_next = ST_NB_NEXT;
      end
      ST_NB_NEXT: begin
        if (k != 3'd7) begin
          state_next = ST_NB_ADDR;
        end else if (!interp_mode) begin
          state_next = ST_IDLE;
          fin        = 1'b1;
          fin_used   = (nn != 4'd0);
          fin_count  = nn;
        end else if (sum_w == 20'd0) begin
          state_next = ST_IDLE;
          fin        = 1'b1;
          fin_count  = nn;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        state_next = (step == 3'd7) ? ST_TRI_RD : ST_DIV;
      end
      ST_TRI_RD: begin
        bin_addr   = {req.level[BIN_IW-1:0], quo};
        state_next = ST_TRI_WR;
      end
      ST_TRI_WR: begin
        bin_we     = 1'b1;
        bin_addr   = {req.level[BIN_IW-1:0], quo};
        bin_wdata  = sat_add(bin_q, 17'h10000);
        state_next = ST_IDLE;
        fin        = 1'b1;
        fin_used   = 1'b1;
        fin_count  = nn;
      end
      ST_READ_OUT: begin
        state_next = ST_IDLE;
        fin        = 1'b1;
        fin_bin    = bin_q;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep control.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      clr_report <= 1'b0;
    end else if (state == ST_CLEAR) begin
      clr <= clr + 1'b1;
    end else if (state == ST_DECODE) begin
      clr        <= '0;
      clr_report <= 1'b1;
    end
  end

  // Result strobe and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      result.bin_value       <= fin_bin;
      result.voxel_used      <= fin_used;
      result.neighbour_count <= fin_count;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= 1'b0;
      source_bins <= 9'(MAX_BINS);
      target_bins <= 9'(MAX_BINS);
      extent_x    <= 7'(VOLUME_SIDE);
      extent_y    <= 7'(VOLUME_SIDE);
      extent_z    <= 7'(VOLUME_SIDE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERP_MODE: interp_mode <= cfg_data[0];
        CFG_SOURCE_BINS: source_bins <= cfg_data;
        CFG_TARGET_BINS: target_bins <= cfg_data;
        CFG_EXTENT_X:    extent_x    <= cfg_data[6:0];
        CFG_EXTENT_Y:    extent_y    <= cfg_data[6:0];
        CFG_EXTENT_Z:    extent_z    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Affine coefficients.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEFF_COUNT; i++) begin
        coeff[i] <= '0;
      end
    end else if (state == ST_DECODE && req.mode == MODE_WRITE_COEFF &&
                 req.coeff_index < 4'(COEFF_COUNT)) begin
      coeff[req.coeff_index] <= req.coeff_value;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req <= request;
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_DECODE: begin
        nn    <= '0;
        axis  <= '0;
        term  <= '0;
        k     <= '0;
        sum_w <= '0;
        sum_n <= '0;
        acc   <= ACC_W'(coeff[3]);
      end
      ST_AFF_ADD: begin
        acc  <= acc + mul_p[ACC_W-1:0];
        term <= (term == 2'd2) ? term : term + 2'd1;
      end
      ST_AFF_CHECK: begin
        unique case (axis)
          2'd0: begin
            flx <= t1[22:16] - 7'd1;
            frx <= t1[15:0];
          end
          2'd1: begin
            fly <= t1[22:16] - 7'd1;
            fry <= t1[15:0];
          end
          default: begin
            flz <= t1[22:16] - 7'd1;
            frz <= t1[15:0];
          end
        endcase
        if (axis != 2'd2) begin
          axis <= axis + 2'd1;
          term <= '0;
          acc  <= ACC_W'(coeff[{axis + 2'd1, 2'd3}]);
        end
      end
      ST_NB_LABEL: begin
        lab <= tv_q;
      end
      ST_NB_W2: begin
        wt    <= wt_calc;
        nn    <= nn + 4'd1;
        sum_w <= sum_w + 20'(wt_calc);
      end
      ST_TRI_ADD: begin
        sum_n <= sum_n + mul_p[27:0];
      end
      ST_NB_NEXT: begin
        k    <= k + 3'd1;
        rem  <= {sum_n, 1'b0} + 29'(sum_w);
        dsh  <= 29'({sum_w, 1'b0}) << 7;
        quo  <= '0;
        step <= '0;
      end
      ST_DIV: begin
        // One quotient bit per cycle, restoring division.
        if (rem >= dsh) begin
          rem <= rem - dsh;
        end
        quo  <= {quo[6:0], (rem >= dsh)};
        dsh  <= dsh >> 1;
        step <= step + 3'd1;
      end
      default: ;
    endcase
  end

  // Target label memory, single port.
  always_ff @(posedge clk) begin
    if (tv_we) begin
      tv_mem[tv_addr] <= tv_wdata;
    end
    tv_q <= tv_mem[tv_addr];
  end

  // Histogram memory, single port.
  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_addr] <= bin_wdata;
    end
    bin_q <= bin_mem[bin_addr];
  end

  // Checks on the sequencer.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.neighbour_count <= 4'd8))
    else $error("neighbour count above eight");

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.voxel_used) |-> (result.neighbour_count != 4'd0))
    else $error("voxel used with no neighbours");

endmodule

@@ verif/joint_histogram_pv_trilinear_test.sv @@
// Self-checking testbench of the joint histogram builder, with its own histogram predictor.
`timescale 1ns / 1ps

module joint_histogram_pv_trilinear_test;
  import jhpv_pkg::*;

  localparam int IDLE_LIMIT = 300000;
  localparam int ITEM_BUDGET = 1350;
  localparam int NUM_PHASES = 8;

  typedef struct {
    request_t req;
    bit       known;
    result_t  res;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     done;
  result_t  result;
  logic     cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;

  // Predicted block state.
  logic [15:0]       label_store [VOL_DEPTH];
  bit                label_written [VOL_DEPTH];
  int                affine [COEFF_COUNT];
  longint unsigned   hist [BIN_DEPTH];
  int unsigned       cfg_regs [6];

  result_t           pending_results [$];
  stim_row_t         directed [$];
  int                errors = 0;
  int                items_sent;
  int                accum_sent;
  int                voxels_used = 0;
  int                results_seen = 0;
  int                idle_cycles = 0;

  joint_histogram_pv_trilinear dut (
    .clk(clk), .rst(rst), .start(start), .request(request), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lim);
    return (v < lim) ? v : lim;
  endfunction

  // Maps a source voxel into target space; false when any axis falls outside.
  function automatic bit map_voxel(request_t r, output longint fl[3], output longint fr[3]);
    longint t;
    longint ext;
    bit ok;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      ext = clampu(cfg_regs[3 + a], VOLUME_SIDE);
      t = longint'(affine[a * 4]) * longint'(r.pos_x) + longint'(affine[a * 4 + 1]) *
          longint'(r.pos_y) + longint'(affine[a * 4 + 2]) * longint'(r.pos_z) +
          longint'(affine[a * 4 + 3]);
      fl[a] = 0;
      fr[a] = 0;
      if (!(t > -65536 && t < ext * 65536)) ok = 1'b0;
      else begin
        fl[a] = ((t + 65536) >>> 16) - 1;
        fr[a] = (t + 65536) & 64'hFFFF;
      end
    end
    return ok;
  endfunction

  // Neighbour k of a mapped voxel; false when outside the configured volume.
  function automatic bit neighbour_addr(longint fl[3], int k, output int addr);
    longint n [3];
    n[0] = fl[0] + ((k >> 2) & 1);
    n[1] = fl[1] + ((k >> 1) & 1);
    n[2] = fl[2] + (k & 1);
    addr = 0;
    for (int a = 0; a < 3; a++)
      if (n[a] < 0 || n[a] >= clampu(cfg_regs[3 + a], VOLUME_SIDE)) return 1'b0;
    addr = int'((n[0] * VOLUME_SIDE + n[1]) * VOLUME_SIDE + n[2]);
    return 1'b1;
  endfunction

  function automatic bit level_accepted(request_t r);
    int lvl;
    lvl = int'(r.level);
    return lvl >= 0 && lvl < int'(clampu(cfg_regs[1], MAX_BINS));
  endfunction

  function automatic void add_to_bin(int idx, longint unsigned amount);
    longint unsigned s;
    s = hist[idx] + amount;
    hist[idx] = (s > 40'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s;
  endfunction

  // Computes the result of one request and updates the predicted state.
  function automatic result_t histogram_step(request_t r);
    result_t res;
    longint fl [3];
    longint fr [3];
    longint unsigned w [3];
    longint unsigned wt;
    longint unsigned sum_w;
    longint unsigned sum_n;
    int addr;
    int lab;
    int lvl;
    int nn;
    int tb;
    res = '0;
    lvl = int'(r.level);
    case (r.mode)
      MODE_WRITE_TARGET: begin
        addr = (int'(r.pos_x) * VOLUME_SIDE + int'(r.pos_y)) * VOLUME_SIDE + int'(r.pos_z);
        label_store[addr] = (lvl < 0 || lvl >= MAX_BINS) ? 16'h8000 : 16'(lvl);
        label_written[addr] = 1'b1;
      end
      MODE_WRITE_COEFF: begin
        if (r.coeff_index < COEFF_COUNT) affine[r.coeff_index] = r.coeff_value;
      end
      MODE_CLEAR: begin
        foreach (hist[i]) hist[i] = 0;
      end
      MODE_ACCUMULATE: begin
        if (level_accepted(r) && map_voxel(r, fl, fr)) begin
          tb = clampu(cfg_regs[2], MAX_BINS);
          nn = 0;
          sum_w = 0;
          sum_n = 0;
          for (int k = 0; k < 8; k++) begin
            if (!neighbour_addr(fl, k, addr)) continue;
            lab = label_store[addr];
            if (lab[15] || lab >= tb) continue;
            w[0] = ((k >> 2) & 1) ? fr[0] : 65536 - fr[0];
            w[1] = ((k >> 1) & 1) ? fr[1] : 65536 - fr[1];
            w[2] = (k & 1) ? fr[2] : 65536 - fr[2];
            wt = (w[0] * w[1] * w[2] + 64'h8000_0000) >> 32;
            nn++;
            sum_w += wt;
            sum_n += wt * lab;
            if (cfg_regs[0] == 0) add_to_bin(lvl * MAX_BINS + lab, wt);
          end
          if (cfg_regs[0] != 0) begin
            if (sum_w > 0) begin
              add_to_bin(lvl * MAX_BINS + int'((2 * sum_n + sum_w) / (2 * sum_w)), 65536);
              res.voxel_used = 1'b1;
            end
          end else begin
            res.voxel_used = nn > 0;
          end
          res.neighbour_count = 4'(nn);
        end
      end
      MODE_READ_BIN: begin
        res.bin_value = 40'(hist[int'(r.read_row) * MAX_BINS + int'(r.read_col)]);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sends one request after a random gap and records its expected result.
  task automatic issue(request_t r, bit known = 1'b0, result_t fixed = '0);
    result_t predicted;
    repeat ($urandom_range(0, 13)) @(negedge clk);
    @(negedge clk);
    start = 1'b1;
    request = r;
    do @(posedge clk); while (busy);
    predicted = histogram_step(r);
    pending_results.push_back(known ? fixed : predicted);
    items_sent++;
    if (r.mode == MODE_ACCUMULATE) accum_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Labels every neighbour that an accumulate request will read, then sends it.
  task automatic accumulate_voxel(request_t r, bit known = 1'b0, result_t fixed = '0);
    longint fl [3];
    longint fr [3];
    int addr;
    request_t wr;
    if (level_accepted(r) && map_voxel(r, fl, fr)) begin
      for (int k = 0; k < 8; k++) begin
        if (neighbour_addr(fl, k, addr) && !label_written[addr]) begin
          wr = '0;
          wr.mode = MODE_WRITE_TARGET;
          wr.pos_x = 6'(addr / (VOLUME_SIDE * VOLUME_SIDE));
          wr.pos_y = 6'((addr / VOLUME_SIDE) % VOLUME_SIDE);
          wr.pos_z = 6'(addr % VOLUME_SIDE);
          wr.level = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
          issue(wr);
        end
      end
    end
    issue(r, known, fixed);
  endtask

  task automatic send(request_t r, bit known = 1'b0, result_t fixed = '0);
    if (r.mode == MODE_ACCUMULATE) accumulate_voxel(r, known, fixed);
    else issue(r, known, fixed);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [8:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    case (idx)
      CFG_INTERP_MODE: cfg_regs[0] = value[0];
      CFG_SOURCE_BINS: cfg_regs[1] = value;
      CFG_TARGET_BINS: cfg_regs[2] = value;
      CFG_EXTENT_X:    cfg_regs[3] = value[6:0];
      CFG_EXTENT_Y:    cfg_regs[4] = value[6:0];
      CFG_EXTENT_Z:    cfg_regs[5] = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Near-identity affine coefficient so that mapped voxels land near their source.
  function automatic request_t coeff_request(int idx);
    request_t r;
    r = '0;
    r.mode = MODE_WRITE_COEFF;
    r.coeff_index = 4'(idx);
    if (idx == 0 || idx == 5 || idx == 10) r.coeff_value = 65536 + $urandom_range(0, 16384) - 8192;
    else if (idx % 4 == 3) r.coeff_value = $urandom_range(0, 4 * 65536) - 65536;
    else r.coeff_value = $urandom_range(0, 8192) - 4096;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.mode = MODE_ACCUMULATE;
      r.pos_x = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7));
      r.pos_y = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7));
      r.pos_z = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7));
      r.level = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    end else if (pick < 60) begin
      r.mode = MODE_WRITE_TARGET;
      r.pos_x = 6'($urandom_range(0, 8));
      r.pos_y = 6'($urandom_range(0, 8));
      r.pos_z = 6'($urandom_range(0, 8));
      r.level = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    end else if (pick < 75) begin
      r.mode = MODE_READ_BIN;
      r.read_row = 8'($urandom_range(0, 20));
      r.read_col = 8'($urandom_range(0, 12));
    end else if (pick < 80) begin
      r = coeff_request($urandom_range(0, 11));
    end else begin
      // Noise on every field; a clear costs a full sweep, so it becomes a read.
      r = request_t'(($bits(request_t))'({$urandom, $urandom, $urandom}));
      r.mode = 3'($urandom_range(0, 7));
      if (r.mode == MODE_CLEAR) r.mode = MODE_READ_BIN;
    end
    return r;
  endfunction

  function automatic request_t make_request(logic [2:0] mode, int x = 0, int y = 0, int z = 0,
                                            int lvl = 0, int idx = 0, int value = 0,
                                            int row = 0, int col = 0);
    request_t r;
    r.mode = mode;
    r.pos_x = 6'(x);
    r.pos_y = 6'(y);
    r.pos_z = 6'(z);
    r.level = 16'(lvl);
    r.coeff_index = 4'(idx);
    r.coeff_value = value;
    r.read_row = 8'(row);
    r.read_col = 8'(col);
    return r;
  endfunction

  task automatic add_row(request_t r, bit known = 1'b0);
    stim_row_t row;
    row.req = r;
    row.known = known;
    row.res = '0;
    directed.push_back(row);
  endtask

  // Result checking and the idle watchdog.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("joint_histogram_pv_trilinear_test NOT OK");
        $finish;
      end
      if (done) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result.voxel_used) voxels_used++;
          if (result.bin_value !== want.bin_value) begin
            $error("bin_value: expected %0d, got %0d", want.bin_value, result.bin_value);
            errors++;
          end
          if (result.voxel_used !== want.voxel_used) begin
            $error("voxel_used: expected %0d, got %0d", want.voxel_used, result.voxel_used);
            errors++;
          end
          if (result.neighbour_count !== want.neighbour_count) begin
            $error("neighbour_count: expected %0d, got %0d", want.neighbour_count,
                   result.neighbour_count);
            errors++;
          end
        end
      end
    end
  end

  // Register settings per phase: interpolation, bins, extents; defaults first.
  int unsigned phase_cfg [NUM_PHASES][6] = '{
    '{0, 256, 256, 64, 64, 64},
    '{1, 256, 256, 64, 64, 64},
    '{0, 16, 8, 8, 8, 8},
    '{1, 4, 300, 5, 6, 7},
    '{0, 1, 1, 1, 1, 1},
    '{1, 511, 2, 127, 0, 3},
    '{0, 0, 256, 64, 64, 64},
    '{1, 200, 13, 9, 9, 9}
  };

  // Main stimulus sequence.
  initial begin
    request_t r;
    items_sent = 0;
    accum_sent = 0;
    foreach (label_written[i]) label_written[i] = 1'b0;
    foreach (label_store[i]) label_store[i] = 16'd0;
    foreach (hist[i]) hist[i] = 0;
    foreach (affine[i]) affine[i] = 0;
    cfg_regs = '{0, 256, 256, 64, 64, 64};
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_INTERP_MODE;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: reset state, identity map, label extremes, rejected voxels.
    add_row(make_request(MODE_READ_BIN, .row(0), .col(0)), 1'b1);
    add_row(make_request(3'd5, 63, 63, 63, -1, 15, -1, 255, 255), 1'b1);
    add_row(make_request(3'd7), 1'b1);
    add_row(make_request(MODE_WRITE_COEFF, .idx(0), .value(32'h10000)), 1'b1);
    add_row(make_request(MODE_WRITE_COEFF, .idx(5), .value(32'h10000)), 1'b1);
    add_row(make_request(MODE_WRITE_COEFF, .idx(10), .value(32'h10000)), 1'b1);
    add_row(make_request(MODE_WRITE_COEFF, .idx(15), .value(32'h7FFFFFFF)), 1'b1);
    add_row(make_request(MODE_WRITE_COEFF, .idx(3), .value(32'h8000)), 1'b1);
    add_row(make_request(MODE_WRITE_TARGET, 0, 0, 0, 3), 1'b1);
    add_row(make_request(MODE_WRITE_TARGET, 63, 63, 63, 255), 1'b1);
    add_row(make_request(MODE_WRITE_TARGET, 1, 0, 0, -1), 1'b1);
    add_row(make_request(MODE_WRITE_TARGET, 0, 1, 0, 256), 1'b1);
    add_row(make_request(MODE_WRITE_TARGET, 0, 0, 1, 32767), 1'b1);
    add_row(make_request(MODE_ACCUMULATE, 0, 0, 0, 0));
    add_row(make_request(MODE_ACCUMULATE, 0, 0, 0, -32768), 1'b1);
    add_row(make_request(MODE_ACCUMULATE, 0, 0, 0, 256), 1'b1);
    add_row(make_request(MODE_ACCUMULATE, 63, 63, 63, 255));
    add_row(make_request(MODE_READ_BIN, .row(0), .col(3)));
    add_row(make_request(MODE_READ_BIN, .row(255), .col(255)));
    add_row(make_request(MODE_CLEAR), 1'b1);
    add_row(make_request(MODE_READ_BIN, .row(0), .col(3)), 1'b1);
    add_row(make_request(MODE_WRITE_COEFF, .idx(3), .value(-32'sh10000)), 1'b1);
    add_row(make_request(MODE_ACCUMULATE, 0, 0, 0, 1), 1'b1);
    foreach (directed[i]) send(directed[i].req, directed[i].known, directed[i].res);

    // Random part, one slice of the request budget per register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p > 0)
        for (int i = 0; i < 6; i++) write_register(3'(i), 9'(phase_cfg[p][i]));
      for (int i = 0; i < COEFF_COUNT; i++) issue(coeff_request(i));
      for (int n = 0; items_sent < (p + 1) * ITEM_BUDGET / NUM_PHASES; n++) begin
        r = random_request();
        send(r);
        // A wild coefficient is followed by a sensible one at the same index.
        if (r.mode == MODE_WRITE_COEFF && r.coeff_index < COEFF_COUNT)
          issue(coeff_request(r.coeff_index));
        if (n == 20) wait_drained();
        if (n == 10 && (p % 3) == 1) issue(make_request(MODE_CLEAR));
      end
    end

    wait_drained();
    $display("Sent %0d requests, %0d of them accumulates over %0d register settings.",
             items_sent, accum_sent, NUM_PHASES);
    $display("Checked %0d results; %0d voxels reached the histogram.", results_seen,
             voxels_used);
    if (errors == 0) begin
      $display("joint_histogram_pv_trilinear_test OK");
    end else begin
      $display("joint_histogram_pv_trilinear_test NOT OK");
    end
    $finish;
  end

endmodule
